### sv/sitda_pkg.sv
// Package: payload types, stage record and BCD conversion helpers.
`timescale 1ns / 1ps
package sitda_pkg;

    localparam int unsigned BIN_W         = 32;
    localparam int unsigned NUM_DIGITS    = 10;
    localparam int unsigned BCD_W         = 4 * NUM_DIGITS;
    localparam int unsigned STEPS_PER_STG = 8;
    localparam int unsigned NUM_DAB_STG   = BIN_W / STEPS_PER_STG;
    localparam logic [5:0]  ASCII_ZERO    = 6'd48;
    localparam logic [5:0]  ASCII_MINUS   = 6'd45;

    typedef struct packed {
        logic signed [31:0] value;
        logic               pad_two;
    } in_t;

    typedef struct packed {
        logic [5:0] ascii_char;
        logic       last;
    } out_t;

    typedef struct packed {
        logic             neg;
        logic             pad;
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } stage_t;

    // One shift-and-add-3 step: correct each digit, then shift in the binary MSB.
    function automatic stage_t dabble_step(input stage_t s);
        stage_t r;
        logic [3:0] d;
        r = s;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = s.bcd[4*i +: 4];
            r.bcd[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        r.bcd = {r.bcd[BCD_W-2:0], s.bin[BIN_W-1]};
        r.bin = {s.bin[BIN_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

### sv/sitda_dabble_stage.sv
// Pipeline stage: eight double-dabble steps with valid/ready and register.
`timescale 1ns / 1ps
module sitda_dabble_stage
    import sitda_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  stage_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output stage_t out_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    always_comb
    begin
        data_next = in_data;
        for (int k = 0; k < STEPS_PER_STG; k++)
        begin
            data_next = dabble_step(data_next);
        end
    end

    // Accept when empty or when the held beat leaves this cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### sv/signed_int_to_decimal_ascii_top.sv
// Top level: signed 32-bit integer to decimal ASCII, one character per beat.
//
//  channel | direction | payload                  | handshake
//  in      | input     | in_t  {value, pad_two}   | in_valid / in_ready
//  out     | output    | out_t {ascii_char, last} | out_valid / out_ready
//
// An input beat passes through the magnitude register and the double-dabble
// stages (eight bit steps each), then enters the character emitter. The
// emitter sends 1 to 11 characters, one per cycle while out_ready is high,
// and loads the next number in the cycle that its last character is taken.
// Reset clears all valid bits and the emitter; a stall on out holds every
// stage and nothing is lost or repeated.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    // Front register: sign, pad flag and magnitude.
    logic   front_valid_reg;
    stage_t front_reg;
    stage_t front_next;
    logic   front_ready;

    logic   stg_valid [NUM_DAB_STG+1];
    logic   stg_ready [NUM_DAB_STG+1];
    stage_t stg_data  [NUM_DAB_STG+1];

    always_comb
    begin
        front_next.neg = in_data.value[BIN_W-1];
        front_next.pad = in_data.pad_two;
        // Unsigned negate also covers the most negative value.
        front_next.bin = in_data.value[BIN_W-1] ? (~in_data.value + 32'd1) : in_data.value;
        front_next.bcd = '0;
    end

    assign front_ready = !front_valid_reg || stg_ready[0];
    assign in_ready    = front_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (front_ready)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_ready && in_valid)
        begin
            front_reg <= front_next;
        end
    end

    assign stg_valid[0] = front_valid_reg;
    assign stg_data[0]  = front_reg;

    // Binary-to-BCD pipeline.
    for (genvar g = 0; g < NUM_DAB_STG; g++)
    begin : g_dab
        sitda_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    // Character emitter.
    logic             busy_reg;
    logic             prefix_reg;   // sign or pad character still to send
    logic             neg_reg;
    logic [3:0]       pos_reg;      // digit being sent, counts down to 0
    logic [BCD_W-1:0] bcd_reg;
    logic             load;
    logic             out_last;
    logic [3:0]       msd;
    logic [3:0]       cur_digit;
    stage_t           tail;

    assign tail = stg_data[NUM_DAB_STG];

    // Find the most significant nonzero digit; zero gives digit 0.
    always_comb
    begin
        msd = 4'd0;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (tail.bcd[4*i +: 4] != 4'd0)
            begin
                msd = 4'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[4*pos_reg +: 4];
    assign out_last  = !prefix_reg && (pos_reg == 4'd0);
    // Take the next number once the last character of this one goes out.
    assign load      = !busy_reg || (out_ready && out_last);
    assign stg_ready[NUM_DAB_STG] = load;

    assign out_valid           = busy_reg;
    assign out_data.ascii_char = prefix_reg ? (neg_reg ? ASCII_MINUS : ASCII_ZERO)
                                            : ASCII_ZERO + {2'b00, cur_digit};
    assign out_data.last       = out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            prefix_reg <= 1'b0;
            pos_reg    <= 4'd0;
        end
        else if (load)
        begin
            busy_reg   <= stg_valid[NUM_DAB_STG];
            prefix_reg <= tail.neg || (tail.pad && (msd == 4'd0));
            pos_reg    <= msd;
        end
        else if (out_ready)
        begin
            // Advance: drop the prefix first, then step down the digits.
            if (prefix_reg)
            begin
                prefix_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && stg_valid[NUM_DAB_STG])
        begin
            neg_reg <= tail.neg;
            bcd_reg <= tail.bcd;
        end
    end

endmodule
